### design/rmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_pkg: shared types and constants for the rational multiply-reduce core
// Field widths, internal datapath widths and the controller/datapath link.
// ----------------------------------------------------------------------------
package rmr_pkg;

    // Fixed port field widths
    localparam int FIELD_W = 32;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 63;
    localparam int IN_TDATA_W  = 4 * FIELD_W;
    localparam int OUT_TDATA_W = 128;

    // Bits of each input field that are used
    localparam int IN_WIDTH = 32;
    localparam int MAG_W    = IN_WIDTH;
    localparam int PROD_W   = 2 * IN_WIDTH - 1;
    localparam int CNT_W    = $clog2(PROD_W + 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture operands
        logic mul;       // form both products
        logic twos;      // strip a common factor of two
        logic keep;      // save the shifted products
        logic gcd;       // one binary gcd step
        logic div_init;  // start a division
        logic div_sel;   // 0: numerator, 1: denominator
        logic div_step;  // one restoring division step
        logic out_load;  // fill the output register
    } t_rmr_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic err;        // a denominator was zero
        logic twos_done;  // one working value is odd
        logic gcd_done;   // gcd sits in the divisor register
    } t_rmr_sts;

    // Two's complement magnitude of the low IN_WIDTH bits
    function automatic logic [MAG_W-1:0] f_mag(input logic [FIELD_W-1:0] raw);
        logic [MAG_W-1:0] v;
        v = raw[MAG_W-1:0];
        return v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
    endfunction

endpackage
`default_nettype wire

### design/rmr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_ctrl: sequencing controller
// Steps one item through multiply, gcd and the two divisions, and owns the
// input ready and the output valid.
// ----------------------------------------------------------------------------
module rmr_ctrl
    import rmr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_rmr_sts i_sts,
    output t_rmr_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_TWOS, S_GCD, S_DIVN, S_DIVD, S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_sts.err ? S_DONE : S_TWOS;
            end
            S_TWOS: begin
                if (i_sts.twos_done) begin
                    o_cmd.keep = 1'b1;
                    n_state    = S_GCD;
                end else begin
                    o_cmd.twos = 1'b1;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIVN;
                end else begin
                    o_cmd.gcd = 1'b1;
                end
            end
            S_DIVN: begin
                if (r_cnt == CNT_W'(PROD_W)) begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_sel  = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + CNT_W'(1);
                end
            end
            S_DIVD: begin
                if (r_cnt == CNT_W'(PROD_W)) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

### design/rmr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmr_dp: arithmetic datapath
// Magnitudes, products, binary gcd, shared restoring divider, output register.
// ----------------------------------------------------------------------------
module rmr_dp
    import rmr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_rmr_cmd           i_cmd,
    input  wire logic [FIELD_W-1:0] i_num_a,
    input  wire logic [FIELD_W-1:0] i_den_a,
    input  wire logic [FIELD_W-1:0] i_num_b,
    input  wire logic [FIELD_W-1:0] i_den_b,
    output t_rmr_sts                o_sts,
    output logic [NUM_W-1:0]        o_prod_num,
    output logic [DEN_W-1:0]        o_prod_den,
    output logic                    o_zero_den_error
);

    logic [MAG_W-1:0]  r_ma, r_mb, r_mda, r_mdb;
    logic [MAG_W-1:0]  w_ma, w_mb, w_mda, w_mdb;
    logic              r_neg, r_err;
    logic [PROD_W-1:0] r_a, r_b, r_pn, r_pd;
    logic [PROD_W-1:0] r_rem, r_quo, r_qn;
    logic [NUM_W-1:0]  r_prod_num;
    logic [DEN_W-1:0]  r_prod_den;
    logic              r_zde;

    logic [2*MAG_W-1:0] w_pnum, w_pden;
    logic [PROD_W:0]    w_shift, w_diff;
    logic               w_ge;
    logic [NUM_W-1:0]   w_qn_ext;

    assign w_ma  = f_mag(i_num_a);
    assign w_mda = f_mag(i_den_a);
    assign w_mb  = f_mag(i_num_b);
    assign w_mdb = f_mag(i_den_b);

    assign w_pnum = r_ma * r_mb;
    assign w_pden = r_mda * r_mdb;

    // restoring division: one quotient bit a step
    assign w_shift  = {r_rem, r_quo[PROD_W-1]};
    assign w_ge     = (w_shift >= {1'b0, r_b});
    assign w_diff   = w_shift - {1'b0, r_b};
    assign w_qn_ext = NUM_W'(r_qn);

    assign o_sts.err       = r_err;
    assign o_sts.twos_done = r_a[0] || r_b[0];
    assign o_sts.gcd_done  = (r_a == '0);

    assign o_prod_num       = r_prod_num;
    assign o_prod_den       = r_prod_den;
    assign o_zero_den_error = r_zde;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_mda <= w_mda;
            r_mdb <= w_mdb;
            r_err <= (w_mda == '0) || (w_mdb == '0);
            r_neg <= (i_num_a[MAG_W-1] ^ i_den_a[MAG_W-1] ^ i_num_b[MAG_W-1] ^
                      i_den_b[MAG_W-1]) && (w_ma != '0) && (w_mb != '0);
        end

        if (i_cmd.mul) begin
            r_a <= w_pnum[PROD_W-1:0];
            r_b <= w_pden[PROD_W-1:0];
        end else if (i_cmd.twos) begin
            r_a <= r_a >> 1;
            r_b <= r_b >> 1;
        end else if (i_cmd.gcd) begin
            priority if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end

        if (i_cmd.keep) begin
            r_pn <= r_a;
            r_pd <= r_b;
        end

        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= i_cmd.div_sel ? r_pd : r_pn;
            if (i_cmd.div_sel) begin
                r_qn <= r_quo;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[PROD_W-1:0] : w_shift[PROD_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
        end

        if (i_cmd.out_load) begin
            r_zde <= r_err;
            if (r_err) begin
                r_prod_num <= '0;
                r_prod_den <= '0;
            end else begin
                r_prod_num <= r_neg ? (NUM_W'(0) - w_qn_ext) : w_qn_ext;
                r_prod_den <= DEN_W'(r_quo);
            end
        end
    end

endmodule
`default_nettype wire

### design/rational_multiply_reduce_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_multiply_reduce_core: product of two fractions in lowest terms
// Multiplies a/b by c/d, puts the sign on the numerator and divides out the
// greatest common divisor.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An item is captured and multiplied, the
// common factors of two are stripped, a binary gcd runs with one shift or one
// subtract a cycle, and the shared restoring divider then divides numerator
// and denominator by it one bit a step before the output register is filled.
// A zero denominator skips the gcd and the divisions and finishes with 0/0
// and the error flag. The result sits in an output register, so the
// next item is taken while the previous result still waits for its transfer.
// No clearing after reset; the block is ready on the first cycle.
// ----------------------------------------------------------------------------
module rational_multiply_reduce_core
    import rmr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // slave side
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: num_a[31:0], den_a[63:32], num_b[95:64], den_b[127:96]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // master side
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: prod_num[63:0], prod_den[126:64], zero pad [127]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: zero_den_error[0]
    output logic                        o_m_axis_tuser
);

    t_rmr_cmd         w_cmd;
    t_rmr_sts         w_sts;
    logic [NUM_W-1:0] w_prod_num;
    logic [DEN_W-1:0] w_prod_den;

    // sequencing
    rmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic; operands are captured on the accepting transfer
    rmr_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_num_a          (i_s_axis_tdata[FIELD_W-1:0]),
        .i_den_a          (i_s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_num_b          (i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
        .i_den_b          (i_s_axis_tdata[4*FIELD_W-1:3*FIELD_W]),
        .o_sts            (w_sts),
        .o_prod_num       (w_prod_num),
        .o_prod_den       (w_prod_den),
        .o_zero_den_error (o_m_axis_tuser)
    );

    // pad the result to whole bytes
    assign o_m_axis_tdata = {{(OUT_TDATA_W - NUM_W - DEN_W){1'b0}}, w_prod_den, w_prod_num};

    // ---- checks ----

    // an input transfer starts work, so the input side closes next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while an item was in progress");

    // an error result carries 0/0
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("error result with non-zero payload");

    // a good result always has a non-zero denominator
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> w_prod_den != '0)
        else $error("zero denominator without error flag");

    // the gcd leaves an odd, non-zero divisor before any division starts
    a_div_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_init |-> w_sts.gcd_done && !w_sts.err)
        else $error("division started before the gcd completed");

endmodule
`default_nettype wire
